// ===== rtl/lla_pkg.sv =====
// Package for the life-like automaton block: command and register codes,
// fixed field widths and the control/status bundles between controller and datapath.
// No dependencies.
package lla_pkg;

  localparam int BOARD_HALVES = 2;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 64;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int MASK_W     = 9;
  localparam int DIM_CFG_W  = 7;
  localparam int OUT_AGE_W  = 16;
  localparam int LIVE_W     = 13;
  localparam int GEN_W      = 32;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_GEN   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_BIRTH    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SURVIVAL = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COLS     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ROWS     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEAD_AGE = 3'd4;

  typedef struct packed {
    logic item_ld;
    logic walk_clr;
    logic clr_step;
    logic clr_zero;
    logic cnt_clear;
    logic wr_cell;
    logic rd_issue;
    logic gen_p0;
    logic gen_p1;
    logic gen_p2;
    logic gen_step;
    logic gen_fin;
    logic out_ld;
  } lla_ctrl_t;

  typedef struct packed {
    logic walk_last;
  } lla_stat_t;

endpackage

// ===== rtl/lla_ctrl.sv =====
// Controller state machine for the life-like automaton block.
// Sequences cell access, board sweeps and result hand-off; uses lla_pkg.
module lla_ctrl
  import lla_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_cmd,
  output logic       out_tvalid,
  input  logic       out_tready,
  output lla_ctrl_t  ctl,
  input  lla_stat_t  stat
);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_WR     = 4'd2;
  localparam logic [3:0] ST_RD     = 4'd3;
  localparam logic [3:0] ST_CLR    = 4'd4;
  localparam logic [3:0] ST_GP0    = 4'd5;
  localparam logic [3:0] ST_GP1    = 4'd6;
  localparam logic [3:0] ST_GP2    = 4'd7;
  localparam logic [3:0] ST_GRUN   = 4'd8;
  localparam logic [3:0] ST_GDRAIN = 4'd9;
  localparam logic [3:0] ST_GFIN   = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    ctl           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    unique case (state_r)
      ST_INIT: begin
        ctl.clr_step = 1'b1;
        ctl.clr_zero = 1'b1;
        if (stat.walk_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          ctl.item_ld  = 1'b1;
          ctl.walk_clr = 1'b1;
          unique case (in_cmd)
            CMD_WRITE: state_nxt = ST_WR;
            CMD_READ:  state_nxt = ST_RD;
            CMD_GEN:   state_nxt = ST_GP0;
            CMD_CLEAR: state_nxt = ST_CLR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WR: begin
        ctl.wr_cell = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_RD: begin
        ctl.rd_issue = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_CLR: begin
        ctl.clr_step = 1'b1;
        if (stat.walk_last) begin
          ctl.cnt_clear = 1'b1;
          state_nxt     = ST_DONE;
        end
      end
      ST_GP0: begin
        ctl.gen_p0 = 1'b1;
        state_nxt  = ST_GP1;
      end
      ST_GP1: begin
        ctl.gen_p1 = 1'b1;
        state_nxt  = ST_GP2;
      end
      ST_GP2: begin
        ctl.gen_p2 = 1'b1;
        state_nxt  = ST_GRUN;
      end
      ST_GRUN: begin
        ctl.gen_step = 1'b1;
        if (stat.walk_last) state_nxt = ST_GDRAIN;
      end
      ST_GDRAIN: begin
        state_nxt = ST_GFIN;
      end
      ST_GFIN: begin
        ctl.gen_fin = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          ctl.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/lla_datapath.sv =====
// Datapath for the life-like automaton block: rule registers, board memories,
// neighbour window, age pipeline, counters and result register; uses lla_pkg.
module lla_datapath
  import lla_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  parameter int AGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [IN_W-1:0]       in_tdata,
  input  lla_ctrl_t             ctl,
  output lla_stat_t             stat,
  output logic [OUT_W-1:0]      out_tdata
);

  localparam int CW       = $clog2(MAX_COLS);
  localparam int RW       = $clog2(MAX_ROWS);
  localparam int CN_W     = $clog2(MAX_COLS + 1);
  localparam int RN_W     = $clog2(MAX_ROWS + 1);
  localparam int HALF_W   = $clog2(BOARD_HALVES);
  localparam int LA_W     = HALF_W + RW;
  localparam int AA_W     = LA_W + CW;
  localparam int COLS_RST = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int ROWS_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam logic [63:0] AGE_TOP64 = (64'd1 << AGE_BITS) - 64'd1;

  function automatic int dim_clamp(input int v, input int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // rule and board-size registers
  logic [MASK_W-1:0]   birth_r, surv_r;
  logic [CN_W-1:0]     cols_use_r;
  logic [RN_W-1:0]     rows_use_r;
  logic [AGE_BITS-1:0] clr_age_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      birth_r    <= MASK_W'(8);
      surv_r     <= MASK_W'(12);
      cols_use_r <= CN_W'(COLS_RST);
      rows_use_r <= RN_W'(ROWS_RST);
      clr_age_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BIRTH:    birth_r    <= cfg_wdata[MASK_W-1:0];
        REG_SURVIVAL: surv_r     <= cfg_wdata[MASK_W-1:0];
        REG_COLS:     cols_use_r <= CN_W'(dim_clamp(int'(cfg_wdata[DIM_CFG_W-1:0]), MAX_COLS));
        REG_ROWS:     rows_use_r <= RN_W'(dim_clamp(int'(cfg_wdata[DIM_CFG_W-1:0]), MAX_ROWS));
        REG_DEAD_AGE: clr_age_r  <= (64'(cfg_wdata) > AGE_TOP64) ? AGE_BITS'(AGE_TOP64)
                                                                 : AGE_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0] it_cmd_r;
  logic [5:0] it_row_r, it_col_r;
  logic       it_set_r;

  always_ff @(posedge clk) begin
    if (ctl.item_ld) begin
      it_cmd_r <= in_tdata[1:0];
      it_row_r <= in_tdata[7:2];
      it_col_r <= in_tdata[13:8];
      it_set_r <= in_tdata[14];
    end
  end

  logic [RW-1:0] it_row_idx;
  logic [CW-1:0] it_col_idx;
  logic          on_board;

  assign it_row_idx = RW'(it_row_r);
  assign it_col_idx = CW'(it_col_r);
  assign on_board   = (int'(it_row_r) < int'(rows_use_r)) && (int'(it_col_r) < int'(cols_use_r));

  // half select, walk counters
  logic [HALF_W-1:0] half_r, half_nxt;
  logic [RW-1:0]     r_r;
  logic [CW-1:0]     c_r;
  logic              row_end;

  assign half_nxt       = HALF_W'(half_r + 1'b1);
  assign row_end        = (c_r == CW'(MAX_COLS - 1));
  assign stat.walk_last = row_end && (r_r == RW'(MAX_ROWS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r <= '0;
      c_r <= '0;
    end else if (ctl.walk_clr) begin
      r_r <= '0;
      c_r <= '0;
    end else if (ctl.clr_step || ctl.gen_step) begin
      if (row_end) begin
        c_r <= '0;
        r_r <= (r_r == RW'(MAX_ROWS - 1)) ? '0 : RW'(r_r + 1'b1);
      end else begin
        c_r <= CW'(c_r + 1'b1);
      end
    end
  end

  // neighbour window
  logic [MAX_COLS-1:0] above_r, mid_r, below_r, col_mask;
  logic [MAX_COLS+1:0] ext_a, ext_m, ext_b;
  logic [2:0]          nb_a, nb_m, nb_b;
  logic [3:0]          nb_cnt;
  logic [RW+1:0]       r_plus2;
  logic                cell_in, was, will, next_row_ok, row1_ok;
  logic [MAX_COLS-1:0] alive_rd_r;

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) col_mask[j] = (j < int'(cols_use_r));
  end

  assign ext_a       = {1'b0, above_r, 1'b0};
  assign ext_m       = {1'b0, mid_r, 1'b0};
  assign ext_b       = {1'b0, below_r, 1'b0};
  assign nb_a        = ext_a[c_r +: 3];
  assign nb_m        = ext_m[c_r +: 3];
  assign nb_b        = ext_b[c_r +: 3];
  assign nb_cnt      = 4'(nb_a[0]) + 4'(nb_a[1]) + 4'(nb_a[2]) + 4'(nb_m[0]) + 4'(nb_m[2])
                     + 4'(nb_b[0]) + 4'(nb_b[1]) + 4'(nb_b[2]);
  assign was         = nb_m[1];
  assign cell_in     = (int'(r_r) < int'(rows_use_r)) && (int'(c_r) < int'(cols_use_r));
  assign will        = cell_in && (was ? surv_r[nb_cnt] : birth_r[nb_cnt]);
  assign r_plus2     = {2'b00, r_r} + (RW+2)'(2);
  assign next_row_ok = int'(r_plus2) < int'(rows_use_r);
  assign row1_ok     = int'(rows_use_r) > 1;

  always_ff @(posedge clk) begin
    if (ctl.gen_p0) above_r <= '0;
    if (ctl.gen_p1) mid_r   <= alive_rd_r & col_mask;
    if (ctl.gen_p2) below_r <= alive_rd_r & col_mask & {MAX_COLS{row1_ok}};
    if (ctl.gen_step && row_end) begin
      above_r <= mid_r;
      mid_r   <= below_r;
      below_r <= alive_rd_r & col_mask & {MAX_COLS{next_row_ok}};
    end
  end

  // age stage: one cell behind the window
  logic                s1_valid_r, s1_will_r, s1_keep_r;
  logic [RW-1:0]       s1_r_r;
  logic [CW-1:0]       s1_c_r;
  logic [AGE_BITS-1:0] age_rd_r, age_inc;
  logic [LIVE_W-1:0]   live_acc_r, live_cnt_r;
  logic [GEN_W-1:0]    gen_cnt_r;

  assign age_inc = (age_rd_r == '1) ? age_rd_r : AGE_BITS'(age_rd_r + 1'b1);

  always_ff @(posedge clk) begin
    s1_r_r    <= r_r;
    s1_c_r    <= c_r;
    s1_will_r <= will;
    s1_keep_r <= cell_in && (was == will);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      live_acc_r <= '0;
      live_cnt_r <= '0;
      gen_cnt_r  <= '0;
      half_r     <= '0;
    end else begin
      s1_valid_r <= ctl.gen_step;
      if (ctl.gen_p0) live_acc_r <= '0;
      else if (s1_valid_r && s1_will_r && live_acc_r != '1)
        live_acc_r <= LIVE_W'(live_acc_r + 1'b1);
      if (ctl.gen_fin) begin
        gen_cnt_r  <= GEN_W'(gen_cnt_r + 1'b1);
        live_cnt_r <= live_acc_r;
        half_r     <= half_nxt;
      end else if (ctl.cnt_clear) begin
        gen_cnt_r  <= '0;
        live_cnt_r <= '0;
      end
    end
  end

  // memory port selection
  logic                al_re, al_wrow, al_wbit, al_wdata;
  logic [LA_W-1:0]     al_raddr, al_waddr;
  logic [CW-1:0]       al_wcol;
  logic                ag_re, ag_we;
  logic [AA_W-1:0]     ag_raddr, ag_waddr;
  logic [AGE_BITS-1:0] ag_wdata;

  always_comb begin
    al_re    = 1'b0;
    al_raddr = {half_r, it_row_idx};
    if (ctl.rd_issue) begin
      al_re = 1'b1;
    end else if (ctl.gen_p0) begin
      al_re    = 1'b1;
      al_raddr = {half_r, RW'(0)};
    end else if (ctl.gen_p1) begin
      al_re    = 1'b1;
      al_raddr = {half_r, RW'(1)};
    end else if (ctl.gen_step && c_r == '0) begin
      al_re    = 1'b1;
      al_raddr = {half_r, r_plus2[RW-1:0]};
    end

    ag_re    = ctl.rd_issue || ctl.gen_step;
    ag_raddr = ctl.rd_issue ? {half_r, it_row_idx, it_col_idx} : {half_r, r_r, c_r};

    al_wrow  = 1'b0;
    al_wbit  = 1'b0;
    al_waddr = {half_r, r_r};
    al_wcol  = it_col_idx;
    al_wdata = it_set_r;
    ag_we    = 1'b0;
    ag_waddr = {half_r, r_r, c_r};
    ag_wdata = '0;
    if (ctl.clr_step) begin
      al_wrow  = 1'b1;
      ag_we    = 1'b1;
      ag_wdata = ctl.clr_zero ? '0 : clr_age_r;
    end else if (ctl.wr_cell && on_board) begin
      al_wbit  = 1'b1;
      al_waddr = {half_r, it_row_idx};
      ag_we    = 1'b1;
      ag_waddr = {half_r, it_row_idx, it_col_idx};
    end else if (s1_valid_r) begin
      al_wbit  = 1'b1;
      al_waddr = {half_nxt, s1_r_r};
      al_wcol  = s1_c_r;
      al_wdata = s1_will_r;
      ag_we    = 1'b1;
      ag_waddr = {half_nxt, s1_r_r, s1_c_r};
      ag_wdata = s1_keep_r ? age_inc : '0;
    end
  end

  // board memories: alive bits one row per word, ages one cell per word
  logic [MAX_COLS-1:0] alive_mem [2**LA_W];
  logic [AGE_BITS-1:0] age_mem   [2**AA_W];

  always_ff @(posedge clk) begin
    if (al_wrow) alive_mem[al_waddr] <= '0;
    else if (al_wbit) alive_mem[al_waddr][al_wcol] <= al_wdata;
    if (al_re) alive_rd_r <= alive_mem[al_raddr];
  end

  always_ff @(posedge clk) begin
    if (ag_we) age_mem[ag_waddr] <= ag_wdata;
    if (ag_re) age_rd_r <= age_mem[ag_raddr];
  end

  // result register
  logic                 out_alive_r;
  logic [OUT_AGE_W-1:0] out_age_r;
  logic [LIVE_W-1:0]    out_live_r;
  logic [GEN_W-1:0]     out_gen_r;

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      if (it_cmd_r == CMD_READ) begin
        out_alive_r <= on_board && alive_rd_r[it_col_idx];
        out_age_r   <= on_board ? OUT_AGE_W'(age_rd_r) : '0;
      end else begin
        out_alive_r <= 1'b0;
        out_age_r   <= '0;
      end
      out_live_r <= live_cnt_r;
      out_gen_r  <= gen_cnt_r;
    end
  end

  assign out_tdata = {2'b00, out_gen_r, out_live_r, out_age_r, out_alive_r};

endmodule

// ===== rtl/life_like_automaton_generation.sv =====
// Top level of the life-like (B/S rule) automaton block with a double-buffered board.
// Instantiates lla_ctrl and lla_datapath; uses lla_pkg.
//
// channel | direction | transfer when         | content
// in_     | slave     | in_tvalid & in_tready | command, cell address, state to write
// out_    | master    | out_tvalid & out_tready | read cell or live count and generation
// cfg_    | write     | cfg_we                | rule masks, board size, clear age
//
// A generation sweeps one cell per cycle through the single read port of the age memory.
// After reset one pass over every cell clears the board; in_tready is low meanwhile.
// A finished result waits in the output register while the next item is taken in;
// a further result stalls until it has gone.
module life_like_automaton_generation
  import lla_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  parameter int AGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // command[1:0], cell_row[7:2], cell_col[13:8],
                                            // set_alive[14], zero[15]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // cell_alive[0], cell_age[16:1], live_count[29:17],
                                            // generation_number[61:30], zero[63:62]
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  lla_ctrl_t ctl;
  lla_stat_t stat;

  lla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tdata[1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl),
    .stat       (stat)
  );

  lla_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .AGE_BITS (AGE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .ctl       (ctl),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for life_like_automaton_generation: directed table, then random traffic
// in four idle/stall phases, each result checked against the board predictor or a set value.
// Depends on lla_pkg and the block's RTL only.
module tb_top;
  import lla_pkg::*;

  localparam int BOARD_DIM    = 64;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 29;
  localparam longint TIMEOUT_NS = 5_000_000;

  typedef struct packed {
    logic                 cell_alive;
    logic [OUT_AGE_W-1:0] cell_age;
    logic [LIVE_W-1:0]    live_count;
    logic [GEN_W-1:0]     generation_number;
  } board_resp_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [CFG_W-1:0]      value;
    logic [1:0]            cmd;
    logic [5:0]            row;
    logic [5:0]            col;
    logic                  set_alive;
    logic                  known;
    board_resp_t           want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  // board predictor state
  bit                    board_alive [2][BOARD_DIM][BOARD_DIM];
  bit [OUT_AGE_W-1:0]    board_age   [2][BOARD_DIM][BOARD_DIM];
  bit                    shown_half;
  bit [GEN_W-1:0]        gen_total;
  bit [LIVE_W-1:0]       live_total;
  bit [MASK_W-1:0]       birth_rule = 9'd8;
  bit [MASK_W-1:0]       survive_rule = 9'd12;
  bit [DIM_CFG_W-1:0]    cols_reg = 7'd64;
  bit [DIM_CFG_W-1:0]    rows_reg = 7'd64;
  bit [OUT_AGE_W-1:0]    clear_age = '0;

  board_resp_t expected_reports[$];
  stim_row_t   stim_table[$];
  int          fail_count = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;

  life_like_automaton_generation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int span(input bit [DIM_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > BOARD_DIM) return BOARD_DIM;
    return int'(v);
  endfunction

  task automatic predict_command(input logic [1:0] cmd, input logic [5:0] row,
                                 input logic [5:0] col, input logic alive_in,
                                 output bit has_resp, output board_resp_t resp);
    int rows, cols, n, nr, nc, live;
    bit was, will, nxt;
    rows = span(rows_reg);
    cols = span(cols_reg);
    resp = '0;
    has_resp = 1'b1;
    case (cmd)
      CMD_WRITE: begin
        has_resp = 1'b0;
        if (row < rows && col < cols) begin
          board_alive[shown_half][row][col] = alive_in;
          board_age[shown_half][row][col] = '0;
        end
      end
      CMD_READ: begin
        if (row < rows && col < cols) begin
          resp.cell_alive = board_alive[shown_half][row][col];
          resp.cell_age = board_age[shown_half][row][col];
        end
      end
      CMD_GEN: begin
        nxt = ~shown_half;
        live = 0;
        for (int r = 0; r < BOARD_DIM; r++) begin
          for (int c = 0; c < BOARD_DIM; c++) begin
            if (r >= rows || c >= cols) begin
              board_alive[nxt][r][c] = 1'b0;
              board_age[nxt][r][c] = '0;
            end else begin
              n = 0;
              for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                  nr = r + dr;
                  nc = c + dc;
                  if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < rows && nc < cols)
                    n += board_alive[shown_half][nr][nc];
                end
              end
              was = board_alive[shown_half][r][c];
              will = was ? survive_rule[n] : birth_rule[n];
              board_alive[nxt][r][c] = will;
              if (was == will)
                board_age[nxt][r][c] = (board_age[shown_half][r][c] == '1) ? '1 :
                                       board_age[shown_half][r][c] + 1'b1;
              else
                board_age[nxt][r][c] = '0;
              if (will && live < 8191) live++;
            end
          end
        end
        gen_total = gen_total + 1'b1;
        live_total = LIVE_W'(live);
        shown_half = nxt;
      end
      CMD_CLEAR: begin
        for (int h = 0; h < 2; h++)
          for (int r = 0; r < BOARD_DIM; r++)
            for (int c = 0; c < BOARD_DIM; c++) begin
              board_alive[h][r][c] = 1'b0;
              board_age[h][r][c] = clear_age;
            end
        gen_total = '0;
        live_total = '0;
      end
    endcase
    resp.live_count = live_total;
    resp.generation_number = gen_total;
  endtask

  // Lower valid and wait until every expected result has been transferred.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_BIRTH:    birth_rule = val[MASK_W-1:0];
      REG_SURVIVAL: survive_rule = val[MASK_W-1:0];
      REG_COLS:     cols_reg = val[DIM_CFG_W-1:0];
      REG_ROWS:     rows_reg = val[DIM_CFG_W-1:0];
      REG_DEAD_AGE: clear_age = val[OUT_AGE_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_command(input logic [1:0] cmd, input logic [5:0] row,
                              input logic [5:0] col, input logic alive_in,
                              input logic known, input board_resp_t want);
    bit has_resp;
    board_resp_t resp;
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_tdata <= {1'b0, alive_in, col, row, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_command(cmd, row, col, alive_in, has_resp, resp);
    if (has_resp) expected_reports.push_back(known ? want : resp);
  endtask

  task automatic add_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.value = val;
    stim_table.push_back(s);
  endtask

  task automatic add_cmd(input logic [1:0] cmd, input logic [5:0] row, input logic [5:0] col,
                         input logic alive_in, input logic known, input board_resp_t want);
    stim_row_t s;
    s = '0;
    s.cmd = cmd;
    s.row = row;
    s.col = col;
    s.set_alive = alive_in;
    s.known = known;
    s.want = want;
    stim_table.push_back(s);
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk) begin
    board_resp_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        w = expected_reports.pop_front();
        if (out_tdata[0] !== w.cell_alive) begin
          $error("cell_alive: expected %0d, got %0d", w.cell_alive, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[16:1] !== w.cell_age) begin
          $error("cell_age: expected %0d, got %0d", w.cell_age, out_tdata[16:1]);
          fail_count++;
        end
        if (out_tdata[29:17] !== w.live_count) begin
          $error("live_count: expected %0d, got %0d", w.live_count, out_tdata[29:17]);
          fail_count++;
        end
        if (out_tdata[61:30] !== w.generation_number) begin
          $error("generation_number: expected %0d, got %0d", w.generation_number,
                 out_tdata[61:30]);
          fail_count++;
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL life_like_automaton_generation");
    $finish;
  end

  initial begin
    int idle_tab [4];
    int stall_tab [4];
    int rows, cols, sel;
    logic [5:0] r, c;
    board_resp_t none;
    board_resp_t aged;

    idle_tab = '{0, 75, 0, 27};
    stall_tab = '{0, 0, 75, 27};
    none = '0;
    aged = '0;
    aged.cell_age = 16'hFFFF;

    add_cmd(CMD_READ, 6'd0, 6'd0, 1'b0, 1'b1, none);
    add_cmd(CMD_READ, 6'd63, 6'd63, 1'b0, 1'b1, none);
    // three-cell line on the top edge, L-shape in the far corner
    add_cmd(CMD_WRITE, 6'd0, 6'd0, 1'b1, 1'b0, none);
    add_cmd(CMD_WRITE, 6'd0, 6'd1, 1'b1, 1'b0, none);
    add_cmd(CMD_WRITE, 6'd0, 6'd2, 1'b1, 1'b0, none);
    add_cmd(CMD_WRITE, 6'd63, 6'd63, 1'b1, 1'b0, none);
    add_cmd(CMD_WRITE, 6'd62, 6'd63, 1'b1, 1'b0, none);
    add_cmd(CMD_WRITE, 6'd63, 6'd62, 1'b1, 1'b0, none);
    add_cmd(CMD_GEN, 6'd0, 6'd0, 1'b0, 1'b0, none);
    add_cmd(CMD_READ, 6'd0, 6'd1, 1'b0, 1'b0, none);
    add_cmd(CMD_READ, 6'd1, 6'd1, 1'b0, 1'b0, none);
    add_cmd(CMD_READ, 6'd63, 6'd63, 1'b0, 1'b0, none);
    add_cmd(CMD_GEN, 6'd0, 6'd0, 1'b0, 1'b0, none);
    add_cmd(CMD_READ, 6'd0, 6'd1, 1'b0, 1'b0, none);
    add_cmd(CMD_WRITE, 6'd0, 6'd1, 1'b0, 1'b0, none);
    add_cmd(CMD_READ, 6'd0, 6'd1, 1'b0, 1'b0, none);
    // zero columns acts as one, oversize rows as the maximum
    add_cfg(REG_COLS, 16'd0);
    add_cfg(REG_ROWS, 16'd127);
    add_cmd(CMD_READ, 6'd0, 6'd5, 1'b0, 1'b0, none);
    add_cmd(CMD_WRITE, 6'd0, 6'd5, 1'b1, 1'b0, none);
    add_cmd(CMD_GEN, 6'd0, 6'd0, 1'b0, 1'b0, none);
    add_cfg(REG_COLS, 16'd64);
    add_cfg(REG_ROWS, 16'd64);
    add_cmd(CMD_READ, 6'd1, 6'd1, 1'b0, 1'b0, none);
    // clear at top age, then ages saturate
    add_cfg(REG_DEAD_AGE, 16'hFFFF);
    add_cfg(REG_BIRTH, 16'd0);
    add_cfg(REG_SURVIVAL, 16'h01FF);
    add_cmd(CMD_CLEAR, 6'd0, 6'd0, 1'b0, 1'b1, none);
    add_cmd(CMD_READ, 6'd5, 6'd5, 1'b0, 1'b1, aged);
    add_cmd(CMD_GEN, 6'd0, 6'd0, 1'b0, 1'b0, none);
    add_cmd(CMD_READ, 6'd5, 6'd5, 1'b0, 1'b0, none);
    // birth on any count fills the whole board
    add_cfg(REG_BIRTH, 16'h01FF);
    add_cmd(CMD_GEN, 6'd0, 6'd0, 1'b0, 1'b0, none);
    add_cmd(CMD_READ, 6'd0, 6'd0, 1'b0, 1'b0, none);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg)
        write_reg(stim_table[i].reg_idx, stim_table[i].value);
      else
        send_command(stim_table[i].cmd, stim_table[i].row, stim_table[i].col,
                     stim_table[i].set_alive, stim_table[i].known, stim_table[i].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_BIRTH, 16'd8);
          write_reg(REG_SURVIVAL, 16'd12);
          write_reg(REG_COLS, 16'd8);
          write_reg(REG_ROWS, 16'd6);
        end
        1: begin
          write_reg(REG_BIRTH, CFG_W'($urandom_range(0, 511)));
          write_reg(REG_SURVIVAL, CFG_W'($urandom_range(0, 511)));
          write_reg(REG_COLS, 16'd1);
          write_reg(REG_ROWS, 16'd40);
        end
        2: begin
          write_reg(REG_BIRTH, CFG_W'($urandom_range(0, 511)));
          write_reg(REG_SURVIVAL, CFG_W'($urandom_range(0, 511)));
          write_reg(REG_COLS, 16'd100);
          write_reg(REG_ROWS, 16'd0);
        end
        default: begin
          write_reg(REG_BIRTH, CFG_W'($urandom_range(0, 511)));
          write_reg(REG_SURVIVAL, CFG_W'($urandom_range(0, 511)));
          write_reg(REG_COLS, CFG_W'($urandom_range(2, 12)));
          write_reg(REG_ROWS, CFG_W'($urandom_range(2, 12)));
        end
      endcase
      write_reg(REG_DEAD_AGE, CFG_W'($urandom_range(0, 65535)));
      sender_idle_pct = idle_tab[phase];
      recv_stall_pct = stall_tab[phase];
      rows = span(rows_reg);
      cols = span(cols_reg);
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
        sel = $urandom_range(0, 99);
        r = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, rows - 1))
                                         : 6'($urandom_range(0, 63));
        c = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, cols - 1))
                                         : 6'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 3) drain_results();
        if (sel < 45)
          send_command(CMD_WRITE, r, c, 1'($urandom_range(0, 1)), 1'b0, none);
        else if (sel < 75)
          send_command(CMD_READ, r, c, 1'($urandom_range(0, 1)), 1'b0, none);
        else if (sel < 95)
          send_command(CMD_GEN, r, c, 1'($urandom_range(0, 1)), 1'b0, none);
        else
          send_command(CMD_CLEAR, r, c, 1'($urandom_range(0, 1)), 1'b0, none);
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("PASS life_like_automaton_generation");
    end else begin
      $display("FAIL life_like_automaton_generation");
    end
    $finish;
  end

endmodule
